>>> src/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; every macro samples on the rising clock edge, reset active low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock table assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock table assertion failed");

`endif

>>> src/pplt_pkg.sv
// types, codes and constants of the priority preemptive lock table
// used by pplt_ctrl, pplt_dp and the top level; no dependencies
package pplt_pkg;

    localparam int RES_BITS  = 64;
    localparam int SLOT_BITS = 4;
    localparam int PRIO_BITS = 8;
    localparam int GOAL_MAX  = 16;

    // item kinds
    typedef enum logic [1:0] {
        KIND_CHECK   = 2'd0,
        KIND_ACQUIRE = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } ctl_sts_t;

    // resources that exist for the given robot and subsystem counts
    function automatic logic [RES_BITS-1:0] valid_res_mask(input int robots, input int subs);
        logic [RES_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < RES_BITS; i++)
        begin
            if ((i >> 2) < robots && (i & 3) < subs)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

>>> src/pplt_ctrl.sv
// controller state machine of the lock table: accept, goal walk, commit
// depends on pplt_pkg
module pplt_ctrl
    import pplt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ctl_cmd_t cmd,
    input  ctl_sts_t sts
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // result register can take a new result
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> src/pplt_dp.sv
// datapath of the lock table: goal tables, walk accumulators, result register
// depends on pplt_pkg
module pplt_dp
    import pplt_pkg::*;
#(
    parameter int ROBOT_COUNT     = 16,
    parameter int SUBSYSTEM_COUNT = 4,
    parameter int GOAL_SLOTS      = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctl_cmd_t                    cmd,
    output ctl_sts_t                    sts,
    input  logic [1:0]                  kind,
    input  logic [SLOT_BITS-1:0]        goal_slot,
    input  logic signed [PRIO_BITS-1:0] priority_req,
    input  logic [RES_BITS-1:0]         resource_mask,
    output logic                        accept,
    output logic [GOAL_MAX-1:0]         evicted_goals,
    output logic                        error
);

    localparam int GW = $clog2(GOAL_SLOTS);
    localparam logic [RES_BITS-1:0] VALID_MASK = valid_res_mask(ROBOT_COUNT, SUBSYSTEM_COUNT);
    localparam logic [SLOT_BITS:0] SLOT_LIMIT = (SLOT_BITS+1)'(GOAL_SLOTS);
    localparam logic [GW-1:0] LAST_GOAL = GW'(GOAL_SLOTS - 1);

    // captured item
    kind_t                        kind_reg;
    logic [SLOT_BITS-1:0]         slot_reg;
    logic signed [PRIO_BITS-1:0]  prio_reg;
    logic [RES_BITS-1:0]          mask_reg;

    // walk state
    logic [GW-1:0]                cnt_reg, cnt_next;
    logic                         blocked_reg, blocked_next;
    logic [GOAL_SLOTS-1:0]        hits_reg, hits_next;

    // goal tables; an inactive goal holds nothing whatever its stored mask says
    logic [GOAL_SLOTS-1:0]        active_reg, active_next;
    logic [RES_BITS-1:0]          goal_res_reg [GOAL_SLOTS];
    logic signed [PRIO_BITS-1:0]  goal_prio_reg [GOAL_SLOTS];

    // result register
    logic                         accept_reg, accept_next;
    logic [GOAL_MAX-1:0]          evicted_reg, evicted_next;
    logic                         error_reg, error_next;

    logic                         overlap;
    logic                         slot_ok;
    logic [GW-1:0]                slot_idx;
    logic [GOAL_SLOTS-1:0]        slot_onehot;
    logic [GOAL_SLOTS-1:0]        evict_vec;
    logic                         table_we;

    assign sts.last = (cnt_reg == LAST_GOAL);

    // one goal per cycle: does it own any requested resource
    assign overlap = active_reg[cnt_reg] && ((goal_res_reg[cnt_reg] & mask_reg) != '0);

    // walk accumulators
    always_comb
    begin
        cnt_next     = cnt_reg;
        blocked_next = blocked_reg;
        hits_next    = hits_reg;
        if (cmd.load)
        begin
            cnt_next     = '0;
            blocked_next = 1'b0;
            hits_next    = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + GW'(1);
            if (overlap)
            begin
                hits_next = hits_reg | (GOAL_SLOTS'(1) << cnt_reg);
                if (prio_reg < goal_prio_reg[cnt_reg])
                begin
                    blocked_next = 1'b1;
                end
            end
        end
    end

    // slot decode
    assign slot_ok     = ({1'b0, slot_reg} < SLOT_LIMIT);
    assign slot_idx    = slot_reg[GW-1:0];
    assign slot_onehot = GOAL_SLOTS'(1) << slot_idx;

    // commit: result and table update
    always_comb
    begin
        accept_next  = accept_reg;
        evicted_next = evicted_reg;
        error_next   = error_reg;
        active_next  = active_reg;
        evict_vec    = '0;
        table_we     = 1'b0;
        if (cmd.commit)
        begin
            accept_next  = 1'b0;
            evicted_next = '0;
            error_next   = 1'b0;
            case (kind_reg)
                KIND_CHECK:
                begin
                    if (!slot_ok)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        accept_next = !blocked_reg;
                    end
                end
                KIND_ACQUIRE:
                begin
                    if (!slot_ok)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        evict_vec    = hits_reg | (active_reg & slot_onehot);
                        evicted_next = GOAL_MAX'(evict_vec);
                        active_next  = (active_reg & ~evict_vec) | slot_onehot;
                        table_we     = 1'b1;
                    end
                end
                KIND_RELEASE:
                begin
                    if (!slot_ok || ((active_reg & slot_onehot) == '0))
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        evicted_next = GOAL_MAX'(slot_onehot);
                        active_next  = active_reg & ~slot_onehot;
                    end
                end
                default:
                begin
                    error_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(kind);
            slot_reg <= goal_slot;
            prio_reg <= priority_req;
            mask_reg <= resource_mask & VALID_MASK;
        end
        blocked_reg <= blocked_next;
        hits_reg    <= hits_next;
        accept_reg  <= accept_next;
        evicted_reg <= evicted_next;
        error_reg   <= error_next;
        if (table_we)
        begin
            goal_res_reg[slot_idx]  <= mask_reg;
            goal_prio_reg[slot_idx] <= prio_reg;
        end
    end

    assign accept        = accept_reg;
    assign evicted_goals = evicted_reg;
    assign error         = error_reg;

endmodule

>>> src/priority_preemptive_lock_table_core.sv
// Lock table over robot/subsystem resources with priority preemption. After an item is
// transferred, the single overlap-and-priority unit visits every goal's resource mask in
// turn, then the tables are committed and the result register is loaded. A new item is
// taken only in the idle state that follows the commit. The next item is taken while a
// result still waits in that register, but its commit waits until that result is taken,
// and the input stalls meanwhile. Resource ownership lives in per-goal masks with active
// flags that reset clears, so no clearing pass is needed after reset.
// depends on pplt_pkg, pplt_ctrl, pplt_dp
module priority_preemptive_lock_table_core
    import pplt_pkg::*;
#(
    parameter int ROBOT_COUNT     = 16,
    parameter int SUBSYSTEM_COUNT = 4,
    parameter int GOAL_SLOTS      = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  kind,
    input  logic [SLOT_BITS-1:0]        goal_slot,
    input  logic signed [PRIO_BITS-1:0] priority_req,
    input  logic [RES_BITS-1:0]         resource_mask,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        accept,
    output logic [GOAL_MAX-1:0]         evicted_goals,
    output logic                        error
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer
    pplt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // tables and result register
    pplt_dp #(
        .ROBOT_COUNT     (ROBOT_COUNT),
        .SUBSYSTEM_COUNT (SUBSYSTEM_COUNT),
        .GOAL_SLOTS      (GOAL_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .goal_slot     (goal_slot),
        .priority_req  (priority_req),
        .resource_mask (resource_mask),
        .accept        (accept),
        .evicted_goals (evicted_goals),
        .error         (error)
    );

endmodule

>>> src/pplt_checker.sv
// port-level checks of the lock table, bound to the top level
// depends on assert_macros.svh and priority_preemptive_lock_table_core
`include "assert_macros.svh"

module pplt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        accept,
    input logic [15:0] evicted_goals,
    input logic        error
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

    // the block is busy right after taking an item
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, req_valid && !req_stall, req_stall)

    // a granted check never reports evictions or an error
    `ASSERT_IMPLY(a_accept_alone, clk, rst_n, rsp_valid && accept, evicted_goals == 16'd0 && !error)

    // an error never comes with evicted goals
    `ASSERT_IMPLY(a_error_alone, clk, rst_n, rsp_valid && error, evicted_goals == 16'd0)

endmodule

bind priority_preemptive_lock_table_core pplt_checker u_pplt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .accept        (accept),
    .evicted_goals (evicted_goals),
    .error         (error)
);

>>> verif/priority_preemptive_lock_table_core_test.sv
// self-checking testbench for priority_preemptive_lock_table_core: directed table, then random
// lock traffic checked against an in-bench ownership model; depends on pplt_pkg and the core
module priority_preemptive_lock_table_core_test;
    import pplt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROBOTS       = 16;
    localparam int SUBSYSTEMS   = 4;
    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;

    // kind code that the package leaves unnamed; the block treats it as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [PRIO_BITS-1:0] PRIO_MIN = 8'sh80;
    localparam logic signed [PRIO_BITS-1:0] PRIO_MAX = 8'sh7f;
    localparam logic [RES_BITS-1:0]         ALL_RES  = '1;

    typedef struct packed {
        logic [1:0]                  op;
        logic [SLOT_BITS-1:0]        slot;
        logic signed [PRIO_BITS-1:0] prio;
        logic [RES_BITS-1:0]         mask;
    } lock_req_t;

    typedef struct packed {
        logic                accept;
        logic [GOAL_MAX-1:0] evicted;
        logic                error;
    } lock_rsp_t;

    typedef struct packed {
        lock_req_t req;
        logic      fixed_rsp;
        lock_rsp_t rsp;
    } dir_row_t;

    // directed rows; a typed result is used where fixed_rsp is set
    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{KIND_CHECK,   4'd0,  PRIO_MIN, ALL_RES},     1'b1, '{1'b1, 16'h0000, 1'b0}},
        '{'{KIND_RELEASE, 4'd5,  8'sd0,    64'h0},       1'b1, '{1'b0, 16'h0000, 1'b1}},
        '{'{KIND_UNUSED,  4'd15, PRIO_MAX, ALL_RES},     1'b1, '{1'b0, 16'h0000, 1'b0}},
        '{'{KIND_ACQUIRE, 4'd0,  PRIO_MAX, ALL_RES},     1'b1, '{1'b0, 16'h0000, 1'b0}},
        '{'{KIND_CHECK,   4'd1,  PRIO_MIN, ALL_RES},     1'b1, '{1'b0, 16'h0000, 1'b0}},
        '{'{KIND_CHECK,   4'd1,  PRIO_MAX, 64'h1},       1'b1, '{1'b1, 16'h0000, 1'b0}},
        '{'{KIND_ACQUIRE, 4'd1,  PRIO_MIN, 64'h1},       1'b1, '{1'b0, 16'h0001, 1'b0}},
        '{'{KIND_CHECK,   4'd2,  PRIO_MIN, 64'h8000_0000_0000_0000},
                                                         1'b1, '{1'b1, 16'h0000, 1'b0}},
        '{'{KIND_ACQUIRE, 4'd1,  8'sd5,    64'hf0},      1'b1, '{1'b0, 16'h0002, 1'b0}},
        '{'{KIND_ACQUIRE, 4'd15, 8'sd0,    64'h0},       1'b1, '{1'b0, 16'h0000, 1'b0}},
        '{'{KIND_RELEASE, 4'd15, 8'sd0,    64'h0},       1'b1, '{1'b0, 16'h8000, 1'b0}},
        '{'{KIND_RELEASE, 4'd15, 8'sd0,    64'h0},       1'b1, '{1'b0, 16'h0000, 1'b1}},
        '{'{KIND_ACQUIRE, 4'd2,  -8'sd1,   64'hf00},     1'b0, '0},
        '{'{KIND_ACQUIRE, 4'd3,  8'sd10,   64'hff0},     1'b0, '0},
        '{'{KIND_CHECK,   4'd4,  8'sd9,    64'h100},     1'b0, '0},
        '{'{KIND_CHECK,   4'd4,  8'sd10,   64'hfff},     1'b0, '0},
        '{'{KIND_ACQUIRE, 4'd14, PRIO_MAX, 64'haaaa_5555_aaaa_5555}, 1'b0, '0},
        '{'{KIND_RELEASE, 4'd3,  8'sd0,    64'h0},       1'b0, '0},
        '{'{KIND_UNUSED,  4'd7,  -8'sd1,   64'h0},       1'b1, '{1'b0, 16'h0000, 1'b0}},
        '{'{KIND_ACQUIRE, 4'd7,  PRIO_MIN, 64'h5555_aaaa_5555_aaaa}, 1'b0, '0},
        '{'{KIND_CHECK,   4'd0,  PRIO_MIN, 64'h0},       1'b1, '{1'b1, 16'h0000, 1'b0}},
        '{'{KIND_RELEASE, 4'd7,  8'sd0,    64'h0},       1'b0, '0},
        '{'{KIND_CHECK,   4'd9,  PRIO_MIN, ALL_RES},     1'b0, '0}
    };

    localparam int TOTAL_ITEMS = DIR_ROWS + RANDOM_ITEMS;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        req_valid     = 1'b0;
    logic                        req_stall;
    logic [1:0]                  kind          = '0;
    logic [SLOT_BITS-1:0]        goal_slot     = '0;
    logic signed [PRIO_BITS-1:0] priority_req  = '0;
    logic [RES_BITS-1:0]         resource_mask = '0;
    logic                        rsp_valid;
    logic                        rsp_stall     = 1'b0;
    logic                        accept;
    logic [GOAL_MAX-1:0]         evicted_goals;
    logic                        error;

    // ownership model of the lock table
    logic                        res_held    [RES_BITS] = '{default: 1'b0};
    logic [SLOT_BITS-1:0]        res_owner   [RES_BITS] = '{default: '0};
    logic                        goal_active [GOAL_MAX] = '{default: 1'b0};
    logic signed [PRIO_BITS-1:0] goal_prio   [GOAL_MAX] = '{default: '0};
    logic [RES_BITS-1:0]         goal_res    [GOAL_MAX] = '{default: '0};

    // expected results in transfer order, written at rsp_wr_idx and read at rsp_rd_idx
    lock_rsp_t pending_rsp [TOTAL_ITEMS];
    int        rsp_wr_idx   = 0;
    int        rsp_rd_idx   = 0;
    int        fault_count  = 0;
    int        results_seen = 0;
    int        cycle_count  = 0;

    priority_preemptive_lock_table_core #(
        .ROBOT_COUNT     (ROBOTS),
        .SUBSYSTEM_COUNT (SUBSYSTEMS),
        .GOAL_SLOTS      (SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .goal_slot     (goal_slot),
        .priority_req  (priority_req),
        .resource_mask (resource_mask),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .accept        (accept),
        .evicted_goals (evicted_goals),
        .error         (error)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle counter for the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("priority_preemptive_lock_table_core regression: fail");
        $finish;
    end

    function automatic void note_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    // drop every resource a goal still owns and retire the goal
    function automatic void free_goal(input logic [SLOT_BITS-1:0] g);
        for (int i = 0; i < RES_BITS; i++)
        begin
            if (goal_res[g][i] && res_held[i] && res_owner[i] == g)
            begin
                res_held[i] = 1'b0;
            end
        end
        goal_res[g]    = '0;
        goal_active[g] = 1'b0;
    endfunction

    // apply one transfer to the ownership model and return the result it yields
    function automatic lock_rsp_t predict_lock(input lock_req_t r);
        lock_rsp_t            rsp;
        logic [RES_BITS-1:0]  want;
        logic [SLOT_BITS-1:0] o;
        rsp  = '0;
        want = '0;
        // resources beyond the robot or subsystem count do not exist
        for (int i = 0; i < RES_BITS; i++)
        begin
            if (r.mask[i] && (i / 4) < ROBOTS && (i % 4) < SUBSYSTEMS)
            begin
                want[i] = 1'b1;
            end
        end
        if (r.op == KIND_UNUSED)
        begin
            rsp = '0;
        end
        else if (int'(r.slot) >= SLOTS)
        begin
            rsp.error = 1'b1;
        end
        else if (r.op == KIND_CHECK)
        begin
            // blocked by any owner of strictly higher priority
            rsp.accept = 1'b1;
            for (int i = 0; i < RES_BITS; i++)
            begin
                if (want[i] && res_held[i] &&
                    $signed(r.prio) < $signed(goal_prio[res_owner[i]]))
                begin
                    rsp.accept = 1'b0;
                end
            end
        end
        else if (r.op == KIND_ACQUIRE)
        begin
            // old holding of the same slot goes first
            if (goal_active[r.slot])
            begin
                free_goal(r.slot);
                rsp.evicted[r.slot] = 1'b1;
            end
            // preempt every owner in the way, then take the resource
            for (int i = 0; i < RES_BITS; i++)
            begin
                if (want[i])
                begin
                    if (res_held[i])
                    begin
                        o = res_owner[i];
                        free_goal(o);
                        rsp.evicted[o] = 1'b1;
                    end
                    res_held[i]  = 1'b1;
                    res_owner[i] = r.slot;
                end
            end
            goal_active[r.slot] = 1'b1;
            goal_prio[r.slot]   = r.prio;
            goal_res[r.slot]    = want;
        end
        else
        begin
            if (!goal_active[r.slot])
            begin
                rsp.error = 1'b1;
            end
            else
            begin
                free_goal(r.slot);
                rsp.evicted[r.slot] = 1'b1;
            end
        end
        return rsp;
    endfunction

    // random request biased toward contention: few priorities, sparse masks, live slots
    function automatic lock_req_t random_lock_req();
        lock_req_t            r;
        logic [SLOT_BITS-1:0] live [GOAL_MAX];
        int                   live_count;
        int                   pick;
        live_count = 0;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            r.op = KIND_CHECK;
        end
        else if (pick < 70)
        begin
            r.op = KIND_ACQUIRE;
        end
        else if (pick < 95)
        begin
            r.op = KIND_RELEASE;
        end
        else
        begin
            r.op = KIND_UNUSED;
        end

        for (int g = 0; g < GOAL_MAX; g++)
        begin
            if (goal_active[g])
            begin
                live[live_count] = SLOT_BITS'(g);
                live_count++;
            end
        end
        if (r.op == KIND_RELEASE && live_count != 0 && $urandom_range(99) < 80)
        begin
            r.slot = live[$urandom_range(live_count - 1)];
        end
        else
        begin
            r.slot = SLOT_BITS'($urandom_range(GOAL_MAX - 1));
        end

        pick = $urandom_range(99);
        if (pick < 60)
        begin
            r.prio = PRIO_BITS'($urandom_range(4)) - 8'sd2;
        end
        else if (pick < 80)
        begin
            r.prio = $urandom_range(1) ? PRIO_MAX : PRIO_MIN;
        end
        else
        begin
            r.prio = PRIO_BITS'($urandom);
        end

        pick = $urandom_range(99);
        if (pick < 10)
        begin
            r.mask = '0;
        end
        else if (pick < 15)
        begin
            r.mask = ALL_RES;
        end
        else if (pick < 35)
        begin
            r.mask = {$urandom, $urandom};
        end
        else if (pick < 65)
        begin
            // some subsystems of one robot
            r.mask = RES_BITS'($urandom_range(15)) << (4 * $urandom_range(15));
        end
        else
        begin
            r.mask = '0;
            for (int k = $urandom_range(2); k >= 0; k--)
            begin
                r.mask[$urandom_range(RES_BITS - 1)] = 1'b1;
            end
        end
        return r;
    endfunction

    // offer one request until it is taken, then record what it should produce
    task automatic offer_lock_req(input lock_req_t r, input logic fixed_rsp,
                                  input lock_rsp_t typed_rsp, input bit may_idle);
        lock_rsp_t predicted;
        while (may_idle && $urandom_range(99) < 9)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        kind          <= r.op;
        goal_slot     <= r.slot;
        priority_req  <= r.prio;
        resource_mask <= r.mask;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        predicted = predict_lock(r);
        pending_rsp[rsp_wr_idx] = fixed_rsp ? typed_rsp : predicted;
        rsp_wr_idx++;
    endtask

    // result side: check each transfer, stall at random, hold off once for a long stretch
    initial
    begin
        lock_rsp_t got;
        lock_rsp_t want;
        int        hold_left;
        bit        held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                got = '{accept, evicted_goals, error};
                if (rsp_rd_idx == rsp_wr_idx)
                begin
                    note_fault($sformatf("result with nothing pending: accept %0b evicted %h error %0b",
                                         got.accept, got.evicted, got.error));
                end
                else
                begin
                    want = pending_rsp[rsp_rd_idx];
                    rsp_rd_idx++;
                    if (got.accept !== want.accept || got.evicted !== want.evicted ||
                        got.error !== want.error)
                    begin
                        note_fault($sformatf({"result %0d mismatch: expected accept %0b ",
                                              "evicted %h error %0b, got accept %0b ",
                                              "evicted %h error %0b"},
                                             results_seen, want.accept, want.evicted,
                                             want.error, got.accept, got.evicted, got.error));
                    end
                end
                results_seen++;
            end
            if (!held_once && results_seen >= 200)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < 9);
            end
        end
    end

    // request side and end of run
    initial
    begin
        lock_req_t r;
        lock_rsp_t no_rsp;
        no_rsp = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[i])
        begin
            offer_lock_req(DIR_TABLE[i].req, DIR_TABLE[i].fixed_rsp, DIR_TABLE[i].rsp, 1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = random_lock_req();
            offer_lock_req(r, 1'b0, no_rsp, !(n >= CALM_FIRST && n < CALM_LAST));
        end
        req_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (rsp_rd_idx != rsp_wr_idx)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
        begin
            $display("priority_preemptive_lock_table_core regression: pass");
        end
        else
        begin
            $display("priority_preemptive_lock_table_core regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/pplt_pkg.sv
src/pplt_ctrl.sv
src/pplt_dp.sv
src/priority_preemptive_lock_table_core.sv
src/pplt_checker.sv
verif/priority_preemptive_lock_table_core_test.sv
